// ===== rtl/plti_pkg.sv =====
// shared types, widths and codes of the piecewise linear table interpolator
package plti_pkg;

  // table geometry
  localparam int MAX_POINTS = 512;
  localparam int AW         = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // field widths
  localparam int TIME_W    = 16;
  localparam int VAL_W     = 16;
  localparam int ENTRY_W   = TIME_W + VAL_W;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int EPS_W     = 8;

  // serial divider widths
  localparam int DIVD_W    = 32;
  localparam int DIVS_W    = 16;
  localparam int DIV_CNT_W = $clog2(DIVD_W);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON     = 1'd1;

  // request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // clamp side codes
  localparam logic [1:0] SIDE_INTERP = 2'd0;
  localparam logic [1:0] SIDE_LOW    = 2'd1;
  localparam logic [1:0] SIDE_HIGH   = 2'd2;

  typedef struct packed {
    logic                    req_type;
    logic [8:0]              point_index;
    logic [TIME_W-1:0]       point_time;
    logic signed [VAL_W-1:0] point_value;
    logic [TIME_W-1:0]       query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [1:0]              clamp_side;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/plti_ram.sv =====
// generic single write port, single read port ram with registered read
module plti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/plti_div.sv =====
// restoring serial divider, one quotient bit per cycle
module plti_div (
  input  logic               clk,
  input  logic               rst_n,
  input  plti_pkg::div_req_t req,
  output plti_pkg::div_rsp_t rsp
);
  import plti_pkg::*;

  logic [DIVS_W-1:0]    rem_r;
  logic [DIVD_W-1:0]    quo_r;
  logic [DIVS_W-1:0]    dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIVS_W:0]   rem_sh;
  logic              ge;
  logic [DIVS_W:0]   rem_sub;

  // shift one dividend bit into the partial remainder and try the subtract
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIVD_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
        cnt_r  <= DIV_CNT_W'(DIVD_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
        quo_r <= {quo_r[DIVD_W-2:0], ge};
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |=> !rsp.done)
    else $error("divider done held longer than one cycle");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (req.start && !rsp.busy) |=> (rsp.busy && !rsp.done))
    else $error("divider did not start running");

endmodule

// ===== rtl/piecewise_linear_table_interpolator.sv =====
// top level: breakpoint table, binary search sequencer and interpolation datapath
//
// The block keeps a table of up to MAX_POINTS breakpoints (ascending Q1.15 time,
// signed Q3.12 value) in one on-chip ram. A load item (req_type 0) writes one
// breakpoint in the cycle it is accepted and gives no result; a load with an
// index past the table is dropped. A query item (req_type 1) returns one result
// item: the first value when the query lies below the first time plus epsilon
// (clamp_side 1), the last value when it lies above the last time minus epsilon
// (clamp_side 2), and otherwise the linear interpolation between the segment
// found by a binary search for the first time greater than the query, with the
// quotient truncated toward zero and the sum saturated to 16 bits (clamp_side 0).
// Only one item is in work at a time: in_ready is low from the accept of a query
// until its result has moved into the output register, which then waits for
// out_ready on its own. A load leaves the block idle. A clamped query skips the
// search and goes from the clamp decision to S_DONE. An interpolated query runs
// the binary search, at most ceil(log2(n + 1)) probes for the point count n in
// use with one ram read per probe, then the 32-step serial divider that turns
// the segment product into the offset, which dominates. A full output register
// adds its own wait on top. point_count and epsilon go through the cfg port; the
// user must write them only while the block is idle; it does not enforce this.
module piecewise_linear_table_interpolator (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [plti_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [plti_pkg::CFG_W-1:0]          cfg_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  plti_pkg::in_item_t                  in_item,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output plti_pkg::out_item_t                 out_item
);
  import plti_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for an item
    S_FIRST,  // entry 0 on the read port
    S_LAST,   // last entry on the read port, clamp decision
    S_SRCH,   // one search probe per cycle
    S_SEG0,   // segment start on the read port
    S_SEG1,   // segment end on the read port, multiply
    S_MUL,    // product registered, kick the divider
    S_DIV,    // waiting for the quotient
    S_DONE    // result ready for the output register
  } state_t;

  // configuration registers
  logic [CFG_W-1:0] cfg_point_count_r;
  logic [EPS_W-1:0] cfg_epsilon_r;

  // sequencer and datapath registers
  state_t                    state_r;
  logic [TIME_W-1:0]         q_r;
  logic [TIME_W-1:0]         t0_r;
  logic [VAL_W-1:0]          v0_r;
  logic [TIME_W-1:0]         ts_r;
  logic [VAL_W-1:0]          vs_r;
  logic [CNT_W-1:0]          lo_r;
  logic [CNT_W-1:0]          hi_r;
  logic [CNT_W-1:0]          mid_r;
  logic [CNT_W-1:0]          end_r;
  logic signed [2*TIME_W+1:0] prod_r;
  logic signed [TIME_W:0]    den_r;
  logic                      neg_r;
  logic [VAL_W-1:0]          res_r;
  logic [1:0]                side_r;
  logic                      out_valid_r;
  out_item_t                 out_item_r;

  // next values of the search window
  logic [CNT_W-1:0] lo_nxt;
  logic [CNT_W-1:0] hi_nxt;
  logic [CNT_W-1:0] mid_nxt;
  logic [CNT_W-1:0] seg_end;

  // table ram
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [TIME_W-1:0]  rd_time;
  logic [VAL_W-1:0]   rd_value;

  // clamps and segment arithmetic
  logic [CNT_W-1:0]           n_used;
  logic                       hit_low;
  logic                       hit_high;
  logic signed [TIME_W:0]     seg_dq;
  logic signed [VAL_W:0]      seg_dv;
  logic signed [TIME_W:0]     seg_den;
  logic signed [2*TIME_W+1:0] seg_prod;
  logic [2*TIME_W+1:0]        prod_abs;
  logic [TIME_W:0]            den_abs;
  logic [2*TIME_W+1:0]        quo_signed;
  logic [2*TIME_W+1:0]        sum;

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_fire;

  // saturate the wide sum back to a 16-bit value
  function automatic logic [VAL_W-1:0] sat_val(input logic [2*TIME_W+1:0] s);
    logic all_same;
    all_same = (s[2*TIME_W+1:VAL_W-1] == '0) || (s[2*TIME_W+1:VAL_W-1] == '1);
    if (all_same) begin
      return s[VAL_W-1:0];
    end else if (s[2*TIME_W+1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // point count in use, held to two and the table size
  always_comb begin
    if (cfg_point_count_r < CFG_W'(2)) begin
      n_used = CNT_W'(2);
    end else if (32'(cfg_point_count_r) > 32'(MAX_POINTS)) begin
      n_used = CNT_W'(MAX_POINTS);
    end else begin
      n_used = CNT_W'(cfg_point_count_r);
    end
  end

  // loads go straight into the table
  assign ram_we    = in_fire && (in_item.req_type == REQ_LOAD) &&
                     (32'(in_item.point_index) < 32'(MAX_POINTS));
  assign ram_waddr = AW'(in_item.point_index);
  assign ram_wdata = {in_item.point_time, in_item.point_value};
  assign rd_time   = ram_rdata[ENTRY_W-1 -: TIME_W];
  assign rd_value  = ram_rdata[VAL_W-1:0];

  // end clamps, done in 17 bits so no side can wrap
  assign hit_low  = ({1'b0, q_r} < ({1'b0, t0_r} + (TIME_W+1)'(cfg_epsilon_r)));
  assign hit_high = (({1'b0, q_r} + (TIME_W+1)'(cfg_epsilon_r)) > {1'b0, rd_time});

  // search probe: narrow the window with the entry at mid
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (rd_time > q_r) begin
      hi_nxt = mid_r;
    end else begin
      lo_nxt = mid_r + CNT_W'(1);
    end
    mid_nxt = lo_nxt + ((hi_nxt - lo_nxt) >> 1);
    // segment end held inside one to count minus one
    if (lo_nxt == '0) begin
      seg_end = CNT_W'(1);
    end else if (lo_nxt > (n_used - CNT_W'(1))) begin
      seg_end = n_used - CNT_W'(1);
    end else begin
      seg_end = lo_nxt;
    end
  end

  // read address for the entry that the next state looks at
  always_comb begin
    case (state_r)
      S_IDLE:  ram_raddr = '0;
      S_FIRST: ram_raddr = AW'(n_used - CNT_W'(1));
      S_LAST:  ram_raddr = AW'(n_used >> 1);
      S_SRCH:  ram_raddr = (lo_nxt < hi_nxt) ? AW'(mid_nxt) : AW'(seg_end - CNT_W'(1));
      S_SEG0:  ram_raddr = AW'(end_r);
      default: ram_raddr = '0;
    endcase
  end

  // segment differences and the one multiplier
  always_comb begin
    seg_dq   = {1'b0, q_r} - {1'b0, ts_r};
    seg_dv   = {rd_value[VAL_W-1], rd_value} - {vs_r[VAL_W-1], vs_r};
    seg_den  = {1'b0, rd_time} - {1'b0, ts_r};
    seg_prod = seg_dq * seg_dv;
  end

  // magnitudes into the divider, sign put back afterwards
  always_comb begin
    prod_abs = prod_r[2*TIME_W+1] ? (-prod_r) : prod_r;
    den_abs  = den_r[TIME_W] ? (-den_r) : den_r;

    div_req.start    = (state_r == S_MUL);
    div_req.dividend = prod_abs[DIVD_W-1:0];
    div_req.divisor  = den_abs[DIVS_W-1:0];

    quo_signed = neg_r ? (-{2'b00, div_rsp.quotient}) : {2'b00, div_rsp.quotient};
    sum        = quo_signed + {{(TIME_W+2){vs_r[VAL_W-1]}}, vs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      out_valid_r       <= 1'b0;
      cfg_point_count_r <= CFG_W'(2);
      cfg_epsilon_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POINT_COUNT: cfg_point_count_r <= cfg_data;
          REG_EPSILON:     cfg_epsilon_r     <= cfg_data[EPS_W-1:0];
          default:         ;
        endcase
      end

      // result taken downstream, unless the next one moves in at the same edge
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire && (in_item.req_type == REQ_QUERY)) begin
            q_r     <= in_item.query_time;
            state_r <= S_FIRST;
          end
        end
        S_FIRST: begin
          t0_r    <= rd_time;
          v0_r    <= rd_value;
          state_r <= S_LAST;
        end
        S_LAST: begin
          if (hit_low) begin
            res_r   <= v0_r;
            side_r  <= SIDE_LOW;
            state_r <= S_DONE;
          end else if (hit_high) begin
            res_r   <= rd_value;
            side_r  <= SIDE_HIGH;
            state_r <= S_DONE;
          end else begin
            lo_r    <= '0;
            hi_r    <= n_used;
            mid_r   <= n_used >> 1;
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          lo_r <= lo_nxt;
          hi_r <= hi_nxt;
          if (lo_nxt < hi_nxt) begin
            mid_r <= mid_nxt;
          end else begin
            end_r   <= seg_end;
            state_r <= S_SEG0;
          end
        end
        S_SEG0: begin
          ts_r    <= rd_time;
          vs_r    <= rd_value;
          state_r <= S_SEG1;
        end
        S_SEG1: begin
          if (seg_den == '0) begin
            // flat in time: keep the earlier value
            res_r   <= vs_r;
            side_r  <= SIDE_INTERP;
            state_r <= S_DONE;
          end else begin
            prod_r  <= seg_prod;
            den_r   <= seg_den;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          neg_r   <= prod_r[2*TIME_W+1] ^ den_r[TIME_W];
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_r   <= sat_val(sum);
            side_r  <= SIDE_INTERP;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_item_r.result_value <= res_r;
            out_item_r.clamp_side   <= side_r;
            out_valid_r             <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  plti_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  plti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_item.req_type == REQ_QUERY)) |=> !in_ready)
    else $error("block ready right after taking a query item");

  a_probe_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (mid_r < n_used) && (lo_r < hi_r))
    else $error("search probe outside the table");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_side_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.clamp_side == SIDE_INTERP) ||
                   (out_item.clamp_side == SIDE_LOW) ||
                   (out_item.clamp_side == SIDE_HIGH)))
    else $error("result item with a reserved clamp side");

endmodule

// ===== dv/tb_top.sv =====
// testbench for the piecewise linear table interpolator: stimulus, prediction and result checks
`timescale 1ns / 100ps

module tb_top;
  import plti_pkg::*;

  // receiver hold-off length, no-progress limit and settle times (cycles)
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 64;
  localparam int TARGET_ITEMS   = 1950;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;

  // predictor copy of the breakpoint table and registers, updated on accepted items
  logic [TIME_W-1:0]       tbl_time [MAX_POINTS];
  logic signed [VAL_W-1:0] tbl_val  [MAX_POINTS];
  logic [CFG_W-1:0]        count_reg = CFG_W'(2);
  logic [EPS_W-1:0]        eps_reg   = '0;
  out_item_t               pending_results [$];
  int unsigned             errors       = 0;
  int unsigned             quiet_cycles = 0;

  // stimulus side: times as generated, so queries can aim at the table contents
  logic [TIME_W-1:0] gen_time [MAX_POINTS];
  int unsigned       items_sent  = 0;
  int unsigned       burst_left  = 0;
  int unsigned       hold_reqs   = 0;
  int unsigned       hold_served = 0;
  int                cur_count   = 2;
  int                cur_eps     = 0;

  // receiver stall state
  int unsigned hold_left  = 0;
  int unsigned mode_left  = 0;
  int unsigned ready_mode = 0;
  logic [2:0]  stall_tick = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  piecewise_linear_table_interpolator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // expected result of a query against the current table copy
  function automatic out_item_t lookup_value(input logic [TIME_W-1:0] qt);
    int        n, q, eps, t_lo, t_hi, lo, hi, mid, seg_end, seg_start, span;
    longint    acc;
    out_item_t r;
    // count below 2 acts as 2, above the table size as the table size
    n = (count_reg < 2) ? 2 : ((count_reg > MAX_POINTS) ? MAX_POINTS : int'(count_reg));
    q    = int'(qt);
    eps  = int'(eps_reg);
    t_lo = int'(tbl_time[0]);
    t_hi = int'(tbl_time[n-1]);
    r.clamp_side = SIDE_INTERP;
    if (q < t_lo + eps) begin
      acc = longint'(tbl_val[0]);
      r.clamp_side = SIDE_LOW;
    end else if (q > t_hi - eps) begin
      acc = longint'(tbl_val[n-1]);
      r.clamp_side = SIDE_HIGH;
    end else begin
      // first slot whose time is above the query
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (int'(tbl_time[mid]) > q) hi = mid;
        else lo = mid + 1;
      end
      // keep the segment inside the table even when it is not sorted
      seg_end   = (lo < 1) ? 1 : ((lo > n - 1) ? n - 1 : lo);
      seg_start = seg_end - 1;
      span      = int'(tbl_time[seg_end]) - int'(tbl_time[seg_start]);
      if (span == 0) begin
        acc = longint'(tbl_val[seg_start]);
      end else begin
        // longint division truncates toward zero, also for a falling segment
        acc = longint'(tbl_val[seg_start]) +
              (longint'(q - int'(tbl_time[seg_start])) *
               (longint'(tbl_val[seg_end]) - longint'(tbl_val[seg_start]))) / longint'(span);
      end
    end
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    r.result_value = acc[VAL_W-1:0];
    return r;
  endfunction

  // predictor update, result check and no-progress watchdog, all at the clock edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POINT_COUNT: count_reg = cfg_data;
          REG_EPSILON:     eps_reg   = cfg_data[EPS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready === 1'b1) begin
        if (in_item.req_type == REQ_LOAD) begin
          tbl_time[in_item.point_index] = in_item.point_time;
          tbl_val[in_item.point_index]  = in_item.point_value;
        end else begin
          pending_results.insert(pending_results.size(), lookup_value(in_item.query_time));
        end
      end
      if (out_valid === 1'b1 && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result item: result_value %0d clamp_side %0d",
                 out_item.result_value, out_item.clamp_side);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_item.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d",
                   want.result_value, out_item.result_value);
            errors++;
          end
          if (out_item.clamp_side !== want.clamp_side) begin
            $error("clamp_side: expected %0d, got %0d", want.clamp_side, out_item.clamp_side);
            errors++;
          end
        end
      end
      // nothing moving on either channel for too long means the block hung
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // receiver: a long hold-off on request, otherwise stall modes that change now and then
  always @(posedge clk) begin
    stall_tick <= stall_tick + 3'd1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_served != hold_reqs) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(32, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (stall_tick < 3'd5);
      endcase
    end
  end

  // one item on the input channel, in bursts with random gaps between them
  task automatic send_item(input in_item_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 20);
      // valid only drops when there is a real gap, never low and high in one step
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // load item, the query field carries noise
  task automatic send_load(input int unsigned idx, input logic [TIME_W-1:0] t,
                           input logic [VAL_W-1:0] v);
    in_item_t item;
    item.req_type    = REQ_LOAD;
    item.point_index = idx[8:0];
    item.point_time  = t;
    item.point_value = v;
    item.query_time  = TIME_W'($urandom_range(0, 65535));
    gen_time[idx]    = t;
    send_item(item);
  endtask

  // query item, the breakpoint fields carry noise
  task automatic send_query(input logic [TIME_W-1:0] q);
    in_item_t item;
    item.req_type    = REQ_QUERY;
    item.point_index = 9'($urandom_range(0, MAX_POINTS - 1));
    item.point_time  = TIME_W'($urandom_range(0, 65535));
    item.point_value = VAL_W'($urandom_range(0, 65535));
    item.query_time  = q;
    send_item(item);
  endtask

  // stop sending and wait for every outstanding result, then let a load settle
  task automatic wait_idle();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers, back to back, only while the block is idle
  task automatic set_config(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] eps_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_POINT_COUNT;
    cfg_data  <= count;
    @(posedge clk);
    cfg_index <= REG_EPSILON;
    cfg_data  <= eps_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_count  = (count < 2) ? 2 : ((count > MAX_POINTS) ? MAX_POINTS : int'(count));
    cur_eps    = int'(eps_word[EPS_W-1:0]);
  endtask

  // ascending times over the first n slots, sometimes running past 1.0
  task automatic rebuild_table(input int unsigned n);
    int unsigned t, max_step, i;
    t        = $urandom_range(0, 2000);
    max_step = (($urandom_range(0, 3) == 0) ? 2 * 65535 : 2 * 32768) / n;
    for (i = 0; i < n; i++) begin
      send_load(i, t[TIME_W-1:0], VAL_W'($urandom_range(0, 65535)));
      t = t + $urandom_range(0, max_step);
      if (t > 65535) t = 65535;
    end
  endtask

  // queries aimed at the table, with some stray loads mixed in
  task automatic run_queries(input int unsigned m);
    int unsigned k, sel;
    int          lo_t, hi_t, b;
    for (k = 0; k < m; k++) begin
      sel  = $urandom_range(0, 99);
      lo_t = int'(gen_time[0]);
      hi_t = int'(gen_time[cur_count-1]);
      if (sel < 12) begin
        send_load($urandom_range(0, MAX_POINTS - 1), TIME_W'($urandom_range(0, 65535)),
                  VAL_W'($urandom_range(0, 65535)));
      end else if (sel < 60) begin
        send_query(TIME_W'($urandom_range(hi_t, lo_t)));
      end else if (sel < 75) begin
        // exactly on a breakpoint, including the last one
        send_query(gen_time[$urandom_range(0, cur_count - 1)]);
      end else if (sel < 88) begin
        // just inside or outside the clamp windows
        case ($urandom_range(0, 3))
          0: b = lo_t + cur_eps - 1;
          1: b = lo_t + cur_eps;
          2: b = hi_t - cur_eps;
          default: b = hi_t - cur_eps + 1;
        endcase
        if (b < 0) b = 0;
        if (b > 65535) b = 65535;
        send_query(b[TIME_W-1:0]);
      end else begin
        send_query(TIME_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  // four points: both clamps, exact breakpoints, extreme values, negative truncation
  task automatic test_directed_segments();
    set_config(10'd4, 10'd0);
    send_load(0, 16'd1000, 16'h8000);
    send_load(1, 16'd8192, 16'h7FFF);
    send_load(2, 16'd16384, 16'h0100);
    send_load(3, 16'd32768, 16'hF000);
    send_query(16'd0);
    send_query(16'd1000);
    send_query(16'd4500);
    send_query(16'd16384);
    send_query(16'd20000);
    // last time with no tolerance lands on the last segment
    send_query(16'd32768);
    // times above 1.0 compare as plain unsigned
    send_query(16'hFFFF);
  endtask

  // widest tolerance: one step either side of both window edges
  task automatic test_epsilon_window();
    wait_idle();
    set_config(10'd4, 10'd255);
    send_query(16'd1254);
    send_query(16'd1255);
    send_query(16'd32513);
    send_query(16'd32514);
  endtask

  // counts of zero and one behave as two; upper data bits of the tolerance are dropped
  task automatic test_count_floor();
    wait_idle();
    set_config(10'd0, 10'd0);
    send_query(16'd5000);
    wait_idle();
    set_config(10'd1, 10'h300);
    send_query(16'd5000);
  endtask

  // segment of zero length gives the earlier value, interpolated side
  task automatic test_equal_times();
    wait_idle();
    set_config(10'd2, 10'd0);
    send_load(1, 16'd1000, 16'd777);
    send_query(16'd1000);
  endtask

  // unsorted table: the search runs off the end onto a falling last segment
  task automatic test_falling_segment();
    wait_idle();
    set_config(10'd5, 10'd0);
    send_load(0, 16'd1000, VAL_W'($urandom_range(0, 65535)));
    send_load(1, 16'd2000, VAL_W'($urandom_range(0, 65535)));
    send_load(2, 16'd3000, VAL_W'($urandom_range(0, 65535)));
    send_load(3, 16'd30000, VAL_W'($urandom_range(0, 65535)));
    send_load(4, 16'd20000, VAL_W'($urandom_range(0, 65535)));
    send_query(16'd20000);
  endtask

  // every slot written, then the largest counts and those past the table size
  task automatic test_full_table();
    wait_idle();
    rebuild_table(MAX_POINTS);
    wait_idle();
    set_config(10'd512, CFG_W'($urandom_range(0, 255)));
    run_queries(80);
    wait_idle();
    set_config(10'd1023, 10'd255);
    run_queries(30);
    wait_idle();
    set_config(10'd513, CFG_W'($urandom_range(0, 1023)));
    run_queries(20);
  endtask

  // receiver holds off while queries keep coming, so the input side must stall
  task automatic test_output_backpressure();
    int unsigned k;
    wait_idle();
    set_config(10'd8, 10'd16);
    hold_reqs++;
    for (k = 0; k < 12; k++) send_query(TIME_W'($urandom_range(gen_time[7], gen_time[0])));
    wait_idle();
  endtask

  // phases of fresh small tables with random settings, now and then a large count
  task automatic test_random_phases();
    logic [CFG_W-1:0] count, eps_word;
    logic             keep_table;
    while (items_sent < TARGET_ITEMS) begin
      wait_idle();
      keep_table = ($urandom_range(0, 9) == 0);
      count      = keep_table ? CFG_W'($urandom_range(0, 1023)) :
                                CFG_W'($urandom_range(2, 40));
      case ($urandom_range(0, 3))
        0: eps_word = 10'd0;
        1: eps_word = 10'd255;
        default: eps_word = CFG_W'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 3) == 0) eps_word[CFG_W-1:EPS_W] = 2'($urandom_range(1, 3));
      set_config(count, eps_word);
      if (!keep_table) rebuild_table(cur_count);
      run_queries($urandom_range(20, 60));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_segments();
    test_epsilon_window();
    test_count_floor();
    test_equal_times();
    test_falling_segment();
    test_full_table();
    test_output_backpressure();
    test_random_phases();
    wait_idle();
    // catch stray results after the last expected one
    repeat (END_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result items never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
